FILE: sv/ttip_pkg.sv
package ttip_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned COUNT_BITS_DEF = 8;

  localparam int unsigned CH_BITS   = 8;
  localparam int unsigned BASE_BITS = 6;
  localparam int unsigned ADDR_BITS = 3;

  localparam logic [BASE_BITS-1:0] BASE_RESET   = BASE_BITS'(10);
  localparam logic                 SIGNED_RESET = 1'b1;

  typedef enum logic {
    REG_NUMBER_BASE = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } reg_idx_e;

  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_LA    = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LZ    = 8'h7A;
  localparam logic [CH_BITS-1:0] CH_UA    = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UZ    = 8'h5A;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_BITS-1:0] LETTER_OFFSET = 8'd10;
  localparam logic [CH_BITS-1:0] NOT_DIGIT     = 8'hFF;

  typedef struct packed {
    logic [CH_BITS-1:0] ch;
    logic               first;
  } item_t;

  typedef struct packed {
    logic [BASE_BITS-1:0] number_base;
    logic                 signed_mode;
  } cfg_t;

  function automatic logic [CH_BITS-1:0] digit_value(input logic [CH_BITS-1:0] c);
    logic [CH_BITS-1:0] d;
    d = NOT_DIGIT;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + LETTER_OFFSET;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA + LETTER_OFFSET;
    end
    return d;
  endfunction

endpackage

FILE: sv/ttip_cfg_regs.sv
module ttip_cfg_regs
  import ttip_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        REG_NUMBER_BASE: cfg_d.number_base = pwdata[BASE_BITS-1:0];
        REG_SIGNED_MODE: cfg_d.signed_mode = pwdata[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NUMBER_BASE: prdata = 32'(cfg_q.number_base);
      REG_SIGNED_MODE: prdata = 32'(cfg_q.signed_mode);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.number_base <= BASE_RESET;
      cfg_q.signed_mode <= SIGNED_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: sv/ttip_in_stage.sv
module ttip_in_stage
  import ttip_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  input  logic  advance_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign ready_o = !valid_q || advance_i;
  assign accept  = valid_i && ready_o;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

FILE: sv/ttip_core.sv
module ttip_core
  import ttip_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  fire_i,
  input  item_t                 item_i,
  output logic                  res_valid_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic [COUNT_BITS-1:0] end_offset_o,
  output logic                  got_digits_o
);

  logic [VALUE_BITS-1:0] acc_q, acc_d, acc_base;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d, cnt_base, cnt_inc;
  logic                  neg_q, neg_d, neg_base;
  logic                  seen_q, seen_d, seen_base;
  logic                  active_q, active_d;
  logic                  is_sign, is_digit;
  logic [CH_BITS-1:0]    dval;
  logic [VALUE_BITS+BASE_BITS-1:0] prod;

  assign acc_base  = item_i.first ? '0 : acc_q;
  assign cnt_base  = item_i.first ? '0 : cnt_q;
  assign neg_base  = item_i.first ? 1'b0 : neg_q;
  assign seen_base = item_i.first ? 1'b0 : seen_q;
  assign cnt_inc   = (&cnt_base) ? cnt_base : cnt_base + COUNT_BITS'(1);

  assign is_sign  = item_i.first &&
                    (item_i.ch == CH_PLUS || (item_i.ch == CH_MINUS && cfg_i.signed_mode));
  assign dval     = digit_value(item_i.ch);
  assign is_digit = dval < CH_BITS'(cfg_i.number_base);
  assign prod     = acc_base * cfg_i.number_base;

  assign value_o      = neg_base ? VALUE_BITS'(0) - acc_base : acc_base;
  assign end_offset_o = seen_base ? cnt_base : '0;
  assign got_digits_o = seen_base;

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    seen_d      = seen_q;
    active_d    = active_q;
    res_valid_o = 1'b0;
    if (fire_i && (item_i.first || active_q)) begin
      acc_d    = acc_base;
      cnt_d    = cnt_base;
      neg_d    = neg_base;
      seen_d   = seen_base;
      active_d = 1'b1;
      if (is_sign) begin
        neg_d = (item_i.ch == CH_MINUS);
        cnt_d = cnt_inc;
      end else if (is_digit) begin
        acc_d  = prod[VALUE_BITS-1:0] + VALUE_BITS'(dval);
        cnt_d  = cnt_inc;
        seen_d = 1'b1;
      end else begin
        active_d    = 1'b0;
        res_valid_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      cnt_q    <= '0;
      neg_q    <= 1'b0;
      seen_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      neg_q    <= neg_d;
      seen_q   <= seen_d;
      active_q <= active_d;
    end
  end

  a_res_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire_i)
    else $error("Result produced without an item.");

  a_res_ends_parse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !active_q)
    else $error("Parse still active after its result.");

  a_no_digit_zero_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> acc_q == '0)
    else $error("Accumulator changed without a digit.");

  a_first_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.first && !res_valid_o) |=> active_q)
    else $error("First character did not start a parse.");

endmodule

FILE: sv/ttip_out_stage.sv
module ttip_out_stage #(
  parameter int unsigned WIDTH = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             can_load_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [WIDTH-1:0] data_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_o    = valid_q;
  assign data_o     = data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule

FILE: sv/text_to_integer_parser.sv
// The character that ends the number is parsed from the input register; its result is
// held in the output register. One character per cycle while the output can load, set
// by the single multiply-add in the parse stage. A stalled master side holds the input
// register and then the slave side. Reset is asynchronous and active low; it empties
// both stages, idles the parser and sets the base to 10 and signed mode to on.
module text_to_integer_parser
  import ttip_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF,
  localparam int unsigned OUT_BITS  = VALUE_BITS + COUNT_BITS,
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // ch
  input  logic                   s_axis_tuser,   // first
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [8*OUT_BYTES-1:0] m_axis_tdata,   // value, end_offset, zero fill
  output logic                   m_axis_tuser,   // got_digits
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_BITS-1:0]   paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  cfg_t                  cfg;
  item_t                 in_item, stage_item;
  logic                  stage_valid, fire, can_load, res_valid, got_digits;
  logic [VALUE_BITS-1:0] value;
  logic [COUNT_BITS-1:0] end_offset;
  logic [OUT_BITS:0]     res_data, out_data;

  assign in_item.ch    = s_axis_tdata;
  assign in_item.first = s_axis_tuser;
  assign fire          = stage_valid && can_load;
  assign res_data      = {got_digits, end_offset, value};

  assign m_axis_tdata = (8*OUT_BYTES)'(out_data[OUT_BITS-1:0]);
  assign m_axis_tuser = out_data[OUT_BITS];

  ttip_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ttip_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .item_i    (in_item),
    .advance_i (fire),
    .valid_o   (stage_valid),
    .item_o    (stage_item)
  );

  ttip_core #(
    .VALUE_BITS (VALUE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .fire_i       (fire),
    .item_i       (stage_item),
    .res_valid_o  (res_valid),
    .value_o      (value),
    .end_offset_o (end_offset),
    .got_digits_o (got_digits)
  );

  ttip_out_stage #(
    .WIDTH (OUT_BITS + 1)
  ) u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .data_i     (res_data),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .data_o     (out_data)
  );

endmodule
